// File: sv/gbm_pkg.sv
package gbm_pkg;

   localparam int COORD_W   = 48;
   localparam int VALUE_W   = 32;
   localparam int SUM_W     = 48;
   localparam int HITS_W    = 16;
   localparam int IDX_W     = 8;
   localparam int GRID_W    = 9;
   localparam int LIM_W     = 13;
   localparam int ADDR_W    = 24;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_W     = 51;
   localparam int DSR_W     = 49;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT  = 3'd5;

   // item functions
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic [COORD_W-1:0] PIXEL_WIDTH_RST  = 48'h0000_0100_0000;
   localparam logic [COORD_W-1:0] PIXEL_HEIGHT_RST = 48'hFFFF_FF00_0000;
   localparam logic [GRID_W-1:0]  GRID_RST         = 9'd256;
   localparam logic [HITS_W-1:0]  HITS_FULL        = 16'hFFFF;
   localparam logic [SUM_W-1:0]   SUM_MAX          = 48'h7FFF_FFFF_FFFF;
   localparam logic [SUM_W-1:0]   SUM_MIN          = 48'h8000_0000_0000;
   localparam logic [VALUE_W-1:0] MEAN_MAX         = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] MEAN_MIN         = 32'h8000_0000;

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [COORD_W-1:0] pixel_width;
      logic [COORD_W-1:0] pixel_height;
      logic [LIM_W-1:0]   cols_lim;
      logic [LIM_W-1:0]   rows_lim;
   } cfg_type;

   typedef struct packed {
      logic               func;
      logic               in_grid;
      logic [ADDR_W-1:0]  addr;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [VALUE_W-1:0] value;
      logic [COORD_W-1:0] corner_x;
      logic [COORD_W-1:0] corner_y;
   } job_type;

   function automatic logic [NUM_W-1:0] sext_num(input logic [COORD_W-1:0] v);
      return {{(NUM_W-COORD_W){v[COORD_W-1]}}, v};
   endfunction

endpackage

// File: sv/gbm_div.sv
module gbm_div import gbm_pkg::*; #(
   parameter int DVD_W = 48,
   parameter int DIV_W = 16,
   parameter int QUO_W = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             busy,
   output logic [QUO_W-1:0] quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] shf_ff, shf_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             take;

   // one restoring step per cycle, dividend bits shift out as quotient bits shift in
   always_comb begin
      trial  = {rem_ff, shf_ff[QUO_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      take   = (trial >= {1'b0, dsr_ff});
      rem_in = rem_ff;
      shf_in = shf_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = DIV_W'(dividend >> QUO_W);
         shf_in = dividend[QUO_W-1:0];
         dsr_in = divisor;
         cnt_in = CNT_W'(QUO_W);
      end else if (cnt_ff != '0) begin
         rem_in = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         shf_in = QUO_W'({shf_ff, take});
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = shf_ff;

endmodule

// File: sv/gbm_front.sv
module gbm_front import gbm_pkg::*; #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [COORD_W-1:0] req_x_coord,
   input  logic [COORD_W-1:0] req_y_coord,
   input  logic [VALUE_W-1:0] req_sample_value,
   input  logic [IDX_W-1:0]   req_read_row,
   input  logic [IDX_W-1:0]   req_read_col,
   output logic               job_valid,
   input  logic               job_ready,
   output job_type            job
);

   localparam int QW_C = $clog2(MAX_COLS + 1);
   localparam int QW_R = $clog2(MAX_ROWS + 1);
   localparam int QW_M = (QW_C > QW_R) ? QW_C : QW_R;
   localparam int QW   = (QW_M > 2) ? QW_M : 2;

   typedef enum logic [4:0] {
      F_IDLE  = 5'b00001,
      F_LOAD  = 5'b00010,
      F_CHECK = 5'b00100,
      F_DIV   = 5'b01000,
      F_PUSH  = 5'b10000
   } fstate_type;

   fstate_type         state_ff, state_in;
   logic               func_ff;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [IDX_W-1:0]   rrow_ff, rcol_ff;
   logic [NUM_W-1:0]   num_x_ff, num_y_ff;
   logic [COORD_W-1:0] prod_x_ff, prod_y_ff;
   logic               rej_x_ff, rej_y_ff, neg_x_ff, neg_y_ff;

   logic [NUM_W-1:0]   mag_x, mag_y;
   logic [DSR_W-1:0]   d2_x, d2_y, dsr_x, dsr_y;
   logic               div_start, busy_x, busy_y;
   logic [QW-1:0]      q_x, q_y;
   logic [55:0]        mul_x, mul_y;
   logic               in_x, in_y;

   gbm_div #(.DVD_W(NUM_W), .DIV_W(DSR_W), .QUO_W(QW)) u_div_x (
      .clock(clock), .reset(reset), .start(div_start), .dividend(mag_x),
      .divisor(dsr_x), .busy(busy_x), .quotient(q_x)
   );

   gbm_div #(.DVD_W(NUM_W), .DIV_W(DSR_W), .QUO_W(QW)) u_div_y (
      .clock(clock), .reset(reset), .start(div_start), .dividend(mag_y),
      .divisor(dsr_y), .busy(busy_y), .quotient(q_y)
   );

   // magnitudes of numerator and doubled pixel size, and pixel size times read index
   always_comb begin
      mag_x = num_x_ff[NUM_W-1] ? (~num_x_ff + 1'b1) : num_x_ff;
      mag_y = num_y_ff[NUM_W-1] ? (~num_y_ff + 1'b1) : num_y_ff;
      d2_x  = {cfg.pixel_width, 1'b0};
      d2_y  = {cfg.pixel_height, 1'b0};
      dsr_x = d2_x[DSR_W-1] ? (~d2_x + 1'b1) : d2_x;
      dsr_y = d2_y[DSR_W-1] ? (~d2_y + 1'b1) : d2_y;
      mul_x = 56'(cfg.pixel_width) * 56'(rcol_ff);
      mul_y = 56'(cfg.pixel_height) * 56'(rrow_ff);
   end

   // index lands in the grid: non-negative and below the columns or rows in use
   always_comb begin
      in_x = !rej_x_ff && !(neg_x_ff && (q_x != '0)) && (64'(q_x) < 64'(cfg.cols_lim));
      in_y = !rej_y_ff && !(neg_y_ff && (q_y != '0)) && (64'(q_y) < 64'(cfg.rows_lim));
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      req_ready = (state_ff == F_IDLE);
      div_start = 1'b0;
      job_valid = (state_ff == F_PUSH);
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = F_LOAD;
            end
         end
         F_LOAD: begin
            state_in = (func_ff == FUNC_READ) ? F_PUSH : F_CHECK;
         end
         F_CHECK: begin
            div_start = 1'b1;
            state_in  = F_DIV;
         end
         F_DIV: begin
            if (!busy_x && !busy_y) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (job_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         x_ff    <= req_x_coord;
         y_ff    <= req_y_coord;
         val_ff  <= req_sample_value;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_col;
      end
      if (state_ff == F_LOAD) begin
         num_x_ff  <= ((sext_num(x_ff) - sext_num(cfg.origin_x)) << 1)
                      + sext_num(cfg.pixel_width);
         num_y_ff  <= ((sext_num(y_ff) - sext_num(cfg.origin_y)) << 1)
                      + sext_num(cfg.pixel_height);
         prod_x_ff <= mul_x[COORD_W-1:0];
         prod_y_ff <= mul_y[COORD_W-1:0];
      end
      if (state_ff == F_CHECK) begin
         rej_x_ff <= (cfg.pixel_width == '0) || (64'(mag_x) >= (64'(dsr_x) << QW));
         rej_y_ff <= (cfg.pixel_height == '0) || (64'(mag_y) >= (64'(dsr_y) << QW));
         neg_x_ff <= num_x_ff[NUM_W-1] ^ cfg.pixel_width[COORD_W-1];
         neg_y_ff <= num_y_ff[NUM_W-1] ^ cfg.pixel_height[COORD_W-1];
      end
   end

   // job towards the back end
   always_comb begin
      job          = '0;
      job.func     = func_ff;
      job.value    = val_ff;
      if (func_ff == FUNC_READ) begin
         job.row      = rrow_ff;
         job.col      = rcol_ff;
         job.corner_x = cfg.origin_x + prod_x_ff;
         job.corner_y = cfg.origin_y + prod_y_ff;
         job.in_grid  = (64'(rrow_ff) < 64'(cfg.rows_lim))
                        && (64'(rcol_ff) < 64'(cfg.cols_lim));
         job.addr     = ADDR_W'(32'(rrow_ff) * MAX_COLS + 32'(rcol_ff));
      end else begin
         job.in_grid = in_x && in_y;
         if (in_x && in_y) begin
            job.row  = IDX_W'(q_y);
            job.col  = IDX_W'(q_x);
            job.addr = ADDR_W'(32'(q_y) * MAX_COLS + 32'(q_x));
         end
      end
   end

endmodule

// File: sv/gbm_fifo.sv
module gbm_fifo import gbm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // two-entry queue between front and back
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

// File: sv/gbm_back.sv
module gbm_back import gbm_pkg::*; #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic               clock,
   input  logic               reset,
   output logic               clearing,
   input  logic               job_valid,
   output logic               job_ready,
   input  job_type            job,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic               rsp_saturated,
   output logic [IDX_W-1:0]   rsp_cell_row,
   output logic [IDX_W-1:0]   rsp_cell_col,
   output logic [COORD_W-1:0] rsp_corner_x,
   output logic [COORD_W-1:0] rsp_corner_y,
   output logic [VALUE_W-1:0] rsp_mean_value,
   output logic [HITS_W-1:0]  rsp_sample_count,
   output logic               rsp_occupied
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENT_W = HITS_W + SUM_W;

   typedef enum logic [4:0] {
      B_CLEAR = 5'b00001,
      B_IDLE  = 5'b00010,
      B_FETCH = 5'b00100,
      B_DIV   = 5'b01000,
      B_RESP  = 5'b10000
   } bstate_type;

   logic [ENT_W-1:0]   mem [DEPTH];
   logic [ENT_W-1:0]   rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENT_W-1:0]   wr_data;

   bstate_type         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   job_type            job_ff;
   logic               sum_neg_ff;

   logic               acc_ff, acc_in, sat_ff, sat_in, occ_ff, occ_in;
   logic [IDX_W-1:0]   row_ff, row_in, col_ff, col_in;
   logic [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [VALUE_W-1:0] mean_ff, mean_in;
   logic [HITS_W-1:0]  cnt_ff, cnt_in;

   logic [HITS_W-1:0]  hits;
   logic [SUM_W-1:0]   sum, sum_mag;
   logic [SUM_W:0]     sum_new;
   logic [SUM_W-1:0]   sum_sat;
   logic               sum_ovf;
   logic               div_start, div_busy;
   logic [SUM_W-1:0]   quo;

   gbm_div #(.DVD_W(SUM_W), .DIV_W(HITS_W), .QUO_W(SUM_W)) u_div_mean (
      .clock(clock), .reset(reset), .start(div_start), .dividend(sum_mag),
      .divisor(hits), .busy(div_busy), .quotient(quo)
   );

   // cell store, registered read
   assign rd_addr = job.addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // saturating accumulate
   always_comb begin
      hits    = rd_data_ff[ENT_W-1:SUM_W];
      sum     = rd_data_ff[SUM_W-1:0];
      sum_mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
      sum_new = {sum[SUM_W-1], sum}
                + {{(SUM_W+1-VALUE_W){job_ff.value[VALUE_W-1]}}, job_ff.value};
      sum_ovf = (sum_new[SUM_W] != sum_new[SUM_W-1]);
      sum_sat = sum_ovf ? (sum_new[SUM_W] ? SUM_MIN : SUM_MAX) : sum_new[SUM_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      job_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = job_ff.addr[AW-1:0];
      wr_data   = '0;
      div_start = 1'b0;
      acc_in    = acc_ff;
      sat_in    = sat_ff;
      occ_in    = occ_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      mean_in   = mean_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (32'(clr_ff) == DEPTH - 1) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               state_in = B_FETCH;
            end
         end
         B_FETCH: begin
            acc_in   = 1'b0;
            sat_in   = 1'b0;
            occ_in   = 1'b0;
            row_in   = '0;
            col_in   = '0;
            cx_in    = '0;
            cy_in    = '0;
            mean_in  = '0;
            cnt_in   = '0;
            state_in = B_RESP;
            if (job_ff.func == FUNC_ADD) begin
               if (job_ff.in_grid) begin
                  row_in = job_ff.row;
                  col_in = job_ff.col;
                  if (hits == HITS_FULL) begin
                     sat_in = 1'b1;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = {hits + 1'b1, sum_sat};
                     acc_in  = 1'b1;
                     sat_in  = sum_ovf;
                  end
               end
            end else begin
               row_in = job_ff.row;
               col_in = job_ff.col;
               cx_in  = job_ff.corner_x;
               cy_in  = job_ff.corner_y;
               if (job_ff.in_grid) begin
                  wr_en = 1'b1;
                  if (hits != '0) begin
                     cnt_in    = hits;
                     occ_in    = 1'b1;
                     div_start = 1'b1;
                     state_in  = B_DIV;
                  end
               end
            end
         end
         B_DIV: begin
            if (!div_busy) begin
               if (!sum_neg_ff) begin
                  mean_in = (quo > SUM_W'(MEAN_MAX)) ? MEAN_MAX : quo[VALUE_W-1:0];
               end else begin
                  mean_in = (quo > SUM_W'(MEAN_MIN)) ? MEAN_MIN
                                                      : (~quo[VALUE_W-1:0] + 1'b1);
               end
               state_in = B_RESP;
            end
         end
         B_RESP: begin
            if (rsp_ready) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      if (job_valid && job_ready) begin
         job_ff <= job;
      end
      if (state_ff == B_FETCH) begin
         sum_neg_ff <= sum[SUM_W-1];
      end
      acc_ff  <= acc_in;
      sat_ff  <= sat_in;
      occ_ff  <= occ_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      mean_ff <= mean_in;
      cnt_ff  <= cnt_in;
   end

   assign clearing         = (state_ff == B_CLEAR);
   assign rsp_valid        = (state_ff == B_RESP);
   assign rsp_accepted     = acc_ff;
   assign rsp_saturated    = sat_ff;
   assign rsp_cell_row     = row_ff;
   assign rsp_cell_col     = col_ff;
   assign rsp_corner_x     = cx_ff;
   assign rsp_corner_y     = cy_ff;
   assign rsp_mean_value   = mean_ff;
   assign rsp_sample_count = cnt_ff;
   assign rsp_occupied     = occ_ff;

endmodule

// File: sv/grid_binning_mean_accumulator_top.sv
// Grid binning accumulator: an add item maps a Q24.24 point to a cell and adds its
// Q16.16 value to the cell's saturating sum and count; a read item returns the cell
// corner, mean, count and occupied flag and then clears the cell. After reset the
// cell store is swept to zero, one cell a cycle, all MAX_ROWS*MAX_COLS cells
// (65536 at the defaults) while req_ready stays low; configuration writes are taken
// throughout. The front end takes an add item through load, check, divide and push
// states, its bit-serial index dividers giving QW = clog2(max(MAX_COLS,MAX_ROWS)+1)
// quotient bits (9 at the defaults), and a read item through load and push. The back
// end takes an add or empty-cell read through fetch and response, an occupied-cell read
// also through the bit-serial mean divider; a two-entry queue lets the two ends overlap.
module grid_binning_mean_accumulator_top import gbm_pkg::*; #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [COORD_W-1:0]   req_x_coord,
   input  logic [COORD_W-1:0]   req_y_coord,
   input  logic [VALUE_W-1:0]   req_sample_value,
   input  logic [IDX_W-1:0]     req_read_row,
   input  logic [IDX_W-1:0]     req_read_col,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_accepted,
   output logic                 rsp_saturated,
   output logic [IDX_W-1:0]     rsp_cell_row,
   output logic [IDX_W-1:0]     rsp_cell_col,
   output logic [COORD_W-1:0]   rsp_corner_x,
   output logic [COORD_W-1:0]   rsp_corner_y,
   output logic [VALUE_W-1:0]   rsp_mean_value,
   output logic [HITS_W-1:0]    rsp_sample_count,
   output logic                 rsp_occupied
);

   logic [COORD_W-1:0] origin_x_ff, origin_y_ff, pixel_width_ff, pixel_height_ff;
   logic [GRID_W-1:0]  grid_width_ff, grid_height_ff;
   cfg_type            cfg;
   logic               clearing;
   logic               front_ready;
   logic               fq_valid, fq_ready, bq_valid, bq_ready;
   job_type            fq_job, bq_job;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         pixel_width_ff  <= PIXEL_WIDTH_RST;
         pixel_height_ff <= PIXEL_HEIGHT_RST;
         grid_width_ff   <= GRID_RST;
         grid_height_ff  <= GRID_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIGIN_X:     origin_x_ff     <= csr_wdata;
            CSR_ORIGIN_Y:     origin_y_ff     <= csr_wdata;
            CSR_PIXEL_WIDTH:  pixel_width_ff  <= csr_wdata;
            CSR_PIXEL_HEIGHT: pixel_height_ff <= csr_wdata;
            CSR_GRID_WIDTH:   grid_width_ff   <= csr_wdata[GRID_W-1:0];
            CSR_GRID_HEIGHT:  grid_height_ff  <= csr_wdata[GRID_W-1:0];
            default: ;
         endcase
      end
   end

   // grid size capped at the store's dimensions
   always_comb begin
      cfg.origin_x     = origin_x_ff;
      cfg.origin_y     = origin_y_ff;
      cfg.pixel_width  = pixel_width_ff;
      cfg.pixel_height = pixel_height_ff;
      cfg.cols_lim     = (LIM_W'(grid_width_ff) > LIM_W'(MAX_COLS))
                         ? LIM_W'(MAX_COLS) : LIM_W'(grid_width_ff);
      cfg.rows_lim     = (LIM_W'(grid_height_ff) > LIM_W'(MAX_ROWS))
                         ? LIM_W'(MAX_ROWS) : LIM_W'(grid_height_ff);
   end

   assign req_ready = front_ready && !clearing;

   gbm_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock(clock), .reset(reset), .cfg(cfg),
      .req_valid(req_valid && !clearing), .req_ready(front_ready),
      .req_func(req_func), .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .req_sample_value(req_sample_value), .req_read_row(req_read_row),
      .req_read_col(req_read_col),
      .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
   );

   gbm_fifo u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
      .out_valid(bq_valid), .out_ready(bq_ready), .out_job(bq_job)
   );

   gbm_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
      .clock(clock), .reset(reset), .clearing(clearing),
      .job_valid(bq_valid), .job_ready(bq_ready), .job(bq_job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_accepted(rsp_accepted), .rsp_saturated(rsp_saturated),
      .rsp_cell_row(rsp_cell_row), .rsp_cell_col(rsp_cell_col),
      .rsp_corner_x(rsp_corner_x), .rsp_corner_y(rsp_corner_y),
      .rsp_mean_value(rsp_mean_value), .rsp_sample_count(rsp_sample_count),
      .rsp_occupied(rsp_occupied)
   );

`ifndef NO_ASSERTIONS
   // no item is taken while the store is being swept
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready) else $error("item taken during clearing sweep");

   // an add result never reports read fields
   a_add_not_occupied: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> !rsp_occupied && (rsp_sample_count == '0))
      else $error("add result carries read fields");

   // an occupied cell has a nonzero count
   a_occupied_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_occupied |-> (rsp_sample_count != '0))
      else $error("occupied cell with zero count");
`endif

endmodule
